/* hw/rtl/ads_pkg.sv */
// Shared types and constants for the auger dosing sequencer.
package ads_pkg;

   // Dosing modes
   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_MAIN = 2'd1,
      MODE_WAIT = 2'd2,
      MODE_SLOW = 2'd3
   } ads_mode_type;

   // Command codes; the fourth code is unused and leaves the state alone
   localparam logic [1:0] CMD_STEP  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_STOP  = 2'd2;

   // Register index map
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET_WEIGHT = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STOP_MARGIN   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WAIT_PERIOD   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PULSE_PERIOD  = 3'd3;

   localparam int unsigned CSR_DATA_WIDTH = 16;

   // Register reset values
   localparam logic [15:0] TARGET_WEIGHT_RESET = 16'd0;
   localparam logic [15:0] STOP_MARGIN_RESET   = 16'd0;
   localparam logic [15:0] WAIT_PERIOD_RESET   = 16'd1000;
   localparam logic [15:0] PULSE_PERIOD_RESET  = 16'd1000;

   // Input beat
   typedef struct packed {
      logic [1:0]         command;
      logic signed [23:0] weight_grams;
      logic [31:0]        now_ms;
   } ads_req_type;

   // Result beat
   typedef struct packed {
      logic [1:0] mode;
      logic       auger_on;
      logic       dosing;
   } ads_rsp_type;

   // Configuration registers
   typedef struct packed {
      logic [15:0] target_weight;
      logic [15:0] stop_margin;
      logic [15:0] wait_period_ms;
      logic [15:0] pulse_period_ms;
   } ads_cfg_type;

   // Sequencer state
   typedef struct packed {
      ads_mode_type mode;
      logic         auger;
      logic [31:0]  wait_start;
      logic [31:0]  pulse_start;
   } ads_state_type;

endpackage

/* hw/rtl/ads_csr.sv */
// Configuration register file of the auger dosing sequencer.
module ads_csr (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write_enable,
   input  logic [ads_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [ads_pkg::CSR_DATA_WIDTH-1:0]      csr_write_data,
   output ads_pkg::ads_cfg_type                    cfg
);

   ads_pkg::ads_cfg_type cfg_ff;
   ads_pkg::ads_cfg_type cfg_in;

   // Write decode; indexes past the map are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            ads_pkg::CSR_TARGET_WEIGHT: cfg_in.target_weight   = csr_write_data;
            ads_pkg::CSR_STOP_MARGIN:   cfg_in.stop_margin     = csr_write_data;
            ads_pkg::CSR_WAIT_PERIOD:   cfg_in.wait_period_ms  = csr_write_data;
            ads_pkg::CSR_PULSE_PERIOD:  cfg_in.pulse_period_ms = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_weight   <= ads_pkg::TARGET_WEIGHT_RESET;
         cfg_ff.stop_margin     <= ads_pkg::STOP_MARGIN_RESET;
         cfg_ff.wait_period_ms  <= ads_pkg::WAIT_PERIOD_RESET;
         cfg_ff.pulse_period_ms <= ads_pkg::PULSE_PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hw/rtl/ads_step.sv */
// Next-state logic of the dosing sequencer for one input beat.
module ads_step (
   input  ads_pkg::ads_state_type cur_state,
   input  ads_pkg::ads_req_type   item,
   input  ads_pkg::ads_cfg_type   cfg,
   output ads_pkg::ads_state_type nxt_state,
   output ads_pkg::ads_rsp_type   rsp
);

   logic signed [24:0] weight_ext;
   logic signed [24:0] target_ext;
   logic signed [24:0] limit_ext;
   logic [16:0]        limit_diff;
   logic [15:0]        limit_floor;
   logic               at_target;
   logic               at_limit;
   logic [31:0]        wait_elapsed;
   logic [31:0]        pulse_elapsed;
   logic               wait_ready;
   logic               pulse_ready;
   ads_pkg::ads_mode_type mode_in;
   logic               auger_in;

   // Weight compares: target, and target minus margin floored at zero
   assign weight_ext  = 25'(item.weight_grams);
   assign target_ext  = signed'({9'b0, cfg.target_weight});
   assign limit_diff  = {1'b0, cfg.target_weight} - {1'b0, cfg.stop_margin};
   assign limit_floor = limit_diff[16] ? 16'd0 : limit_diff[15:0];
   assign limit_ext   = signed'({9'b0, limit_floor});
   assign at_target   = weight_ext >= target_ext;
   assign at_limit    = weight_ext >= limit_ext;

   // Timers, elapsed time taken modulo 2^32
   assign wait_elapsed  = item.now_ms - cur_state.wait_start;
   assign pulse_elapsed = item.now_ms - cur_state.pulse_start;
   assign wait_ready    = wait_elapsed >= {16'b0, cfg.wait_period_ms};
   assign pulse_ready   = pulse_elapsed >= {16'b0, cfg.pulse_period_ms};

   // Next mode
   always_comb begin
      mode_in = cur_state.mode;
      unique case (item.command)
         ads_pkg::CMD_START: mode_in = ads_pkg::MODE_MAIN;
         ads_pkg::CMD_STOP:  mode_in = ads_pkg::MODE_IDLE;
         ads_pkg::CMD_STEP: begin
            if (cur_state.mode != ads_pkg::MODE_IDLE && at_target) begin
               mode_in = ads_pkg::MODE_IDLE;
            end else begin
               unique case (cur_state.mode)
                  ads_pkg::MODE_MAIN: if (at_limit)    mode_in = ads_pkg::MODE_WAIT;
                  ads_pkg::MODE_WAIT: if (wait_ready)  mode_in = ads_pkg::MODE_SLOW;
                  ads_pkg::MODE_SLOW: if (pulse_ready) mode_in = ads_pkg::MODE_WAIT;
                  default:            mode_in = ads_pkg::MODE_IDLE;
               endcase
            end
         end
         default: ;
      endcase
   end

   // Motor drive
   always_comb begin
      auger_in = cur_state.auger;
      unique case (item.command)
         ads_pkg::CMD_START,
         ads_pkg::CMD_STOP: auger_in = 1'b0;
         ads_pkg::CMD_STEP: begin
            if (cur_state.mode != ads_pkg::MODE_IDLE && at_target) begin
               auger_in = 1'b0;
            end else begin
               unique case (cur_state.mode)
                  ads_pkg::MODE_MAIN: auger_in = !at_limit;
                  ads_pkg::MODE_WAIT: auger_in = wait_ready;
                  ads_pkg::MODE_SLOW: if (pulse_ready) auger_in = 1'b0;
                  default:            auger_in = 1'b0;
               endcase
            end
         end
         default: ;
      endcase
   end

   // Timer start times are taken on entry to wait or slow fill
   always_comb begin
      nxt_state.mode        = mode_in;
      nxt_state.auger       = auger_in;
      nxt_state.wait_start  = cur_state.wait_start;
      nxt_state.pulse_start = cur_state.pulse_start;
      if (mode_in == ads_pkg::MODE_WAIT && cur_state.mode != ads_pkg::MODE_WAIT) begin
         nxt_state.wait_start = item.now_ms;
      end
      if (mode_in == ads_pkg::MODE_SLOW && cur_state.mode != ads_pkg::MODE_SLOW) begin
         nxt_state.pulse_start = item.now_ms;
      end
   end

   // Result beat reports the state after the step
   assign rsp.mode     = mode_in;
   assign rsp.auger_on = auger_in;
   assign rsp.dosing   = mode_in != ads_pkg::MODE_IDLE;

endmodule

/* hw/rtl/auger_dosing_sequencer_top.sv */
// Top level of the auger dosing sequencer: input register, step logic, result register.
// A beat accepted into the input register passes through ads_step into the result register.
// Throughput: one beat per cycle while rsp_stall is low; the state loop runs from state_ff through ads_step and back.
// A stalled result holds the input register, which then stalls the request side.
// Reset (synchronous, active high) clears the mode, motor drive, timer starts and both
// valid flags, and sets the registers to target 0, margin 0, both periods 1000 ms.
module auger_dosing_sequencer_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ads_pkg::ads_req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ads_pkg::ads_rsp_type                rsp_data,
   input  logic                                csr_write_enable,
   input  logic [ads_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ads_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);

   ads_pkg::ads_cfg_type   cfg;
   ads_pkg::ads_state_type state_ff;
   ads_pkg::ads_state_type state_in;
   ads_pkg::ads_req_type   in_data_ff;
   ads_pkg::ads_rsp_type   rsp_data_ff;
   ads_pkg::ads_rsp_type   rsp_data_in;
   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   accept;
   logic                   advance;

   ads_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   ads_step u_step (
      .cur_state (state_ff),
      .item      (in_data_ff),
      .cfg       (cfg),
      .nxt_state (state_in),
      .rsp       (rsp_data_in)
   );

   // Handshake: the input beat moves on when the result register is free or draining
   assign advance     = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A start beat always lands in main fill with the motor off
   a_start_main: assert property (@(posedge clock) disable iff (reset)
      advance && in_data_ff.command == ads_pkg::CMD_START |=>
         rsp_valid && rsp_data.mode == ads_pkg::MODE_MAIN && !rsp_data.auger_on)
      else $error("start beat did not enter main fill");

   // A stop beat always lands in idle with the motor off
   a_stop_idle: assert property (@(posedge clock) disable iff (reset)
      advance && in_data_ff.command == ads_pkg::CMD_STOP |=>
         rsp_valid && rsp_data.mode == ads_pkg::MODE_IDLE && !rsp_data.auger_on)
      else $error("stop beat did not enter idle");

   // The reported mode tracks the held state
   a_rsp_tracks_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_data.mode == state_ff.mode && rsp_data.auger_on == state_ff.auger)
      else $error("result beat differs from sequencer state");

   // The motor is never driven while idle or waiting
   a_motor_off: assert property (@(posedge clock) disable iff (reset)
      state_ff.mode == ads_pkg::MODE_IDLE || state_ff.mode == ads_pkg::MODE_WAIT
         |-> !state_ff.auger)
      else $error("auger driven in idle or wait");

endmodule
